// ----- hdl/torus_lattice_edge_rewire_generator_core_defines.svh -----
`ifndef TORUS_LATTICE_EDGE_REWIRE_GENERATOR_CORE_DEFINES_SVH
`define TORUS_LATTICE_EDGE_REWIRE_GENERATOR_CORE_DEFINES_SVH

// implication checked in the same cycle, off while in reset
`define TLERG_AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlerg check failed");

// implication checked in the next cycle, off while in reset
`define TLERG_AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlerg check failed");

// implication checked in the next cycle, live through reset
`define TLERG_AST_NXT_RAW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tlerg check failed");

`endif

// ----- hdl/tlerg_pkg.sv -----
package tlerg_pkg;

    // fixed field widths
    localparam int WORD_W = 32;
    localparam int SIDE_W = 9;
    localparam int RAD_W  = 3;
    localparam int COORD_W = 8;
    localparam int NODE_W = 16;
    localparam int OFF_W  = 4;
    localparam int CFG_IDX_W = 3;

    // parameter defaults
    localparam int MAX_SIDE_DEF       = 256;
    localparam int MAX_RADIUS_DEF     = 7;
    localparam int MAX_NEIGHBOURS_DEF = 224;

    // register reset values
    localparam logic [SIDE_W-1:0] SIDE_RST   = 9'd64;
    localparam logic [RAD_W-1:0]  RADIUS_RST = 3'd1;
    localparam logic [WORD_W-1:0] THRESH_RST = 32'd0;
    localparam logic              MODE_RST   = 1'b0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd3;

    typedef logic signed [OFF_W-1:0] t_off;

    typedef enum logic [3:0] {
        ST_RESTART,
        ST_IDLE,
        ST_NB_MUL,
        ST_C_MUL,
        ST_C_CHK,
        ST_SCAN,
        ST_WRITE,
        ST_ADV,
        ST_PUSH
    } t_state;

    typedef enum logic [1:0] {
        WOP_HOLD,
        WOP_RESTART,
        WOP_STEP,
        WOP_KEEP
    } t_walk_op;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        t_off               i;
        t_off               j;
        logic [NODE_W-1:0]  self_node;
        logic               step_node;
        logic               step_wrap;
        logic               step_lands;
        logic               home_in_use;
    } t_walk_stat;

    // torus distance of one offset
    function automatic logic [RAD_W-1:0] f_torus_abs(t_off d, logic [SIDE_W-1:0] s);
        logic [RAD_W-1:0]  a;
        logic [SIDE_W-1:0] rest;
        a = (d < 0) ? RAD_W'(-d) : RAD_W'(d);
        rest = s - SIDE_W'(a);
        f_torus_abs = (rest < SIDE_W'(a)) ? rest[RAD_W-1:0] : a;
    endfunction

    function automatic logic f_in_use(t_off i, t_off j, logic [SIDE_W-1:0] s,
                                      logic [RAD_W-1:0] k, logic mode);
        logic [RAD_W:0] span;
        span = (RAD_W+1)'(f_torus_abs(i, s)) + (RAD_W+1)'(f_torus_abs(j, s));
        if (i == 0 && j == 0) begin
            f_in_use = 1'b0;
        end else if (mode) begin
            f_in_use = (span <= (RAD_W+1)'(k));
        end else begin
            f_in_use = 1'b1;
        end
    endfunction

endpackage

// ----- hdl/tlerg_mem.sv -----
module tlerg_mem #(
    parameter int DEPTH = tlerg_pkg::MAX_NEIGHBOURS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tlerg_pkg::NODE_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [tlerg_pkg::NODE_W-1:0] o_rdata
);

    logic [tlerg_pkg::NODE_W-1:0] r_mem [DEPTH];
    logic [tlerg_pkg::NODE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tlerg_walk.sv -----
module tlerg_walk #(
    parameter int MAX_NEIGHBOURS = tlerg_pkg::MAX_NEIGHBOURS_DEF,
    parameter int CW = $clog2(MAX_NEIGHBOURS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tlerg_pkg::t_walk_op           i_op,
    input  logic [tlerg_pkg::SIDE_W-1:0]  i_side,
    input  logic [tlerg_pkg::RAD_W-1:0]   i_rad,
    input  logic                          i_mode,
    output tlerg_pkg::t_walk_stat         o_stat,
    output logic [CW-1:0]                 o_kept
);

    logic [tlerg_pkg::COORD_W-1:0] r_x, r_y, n_x, n_y;
    tlerg_pkg::t_off               r_i, r_j, n_i, n_j;
    logic [tlerg_pkg::NODE_W-1:0]  r_self, n_self;
    logic [CW-1:0]                 r_kept;
    logic                          n_node, n_wrap;
    tlerg_pkg::t_off               k_s, neg_k;
    logic [tlerg_pkg::SIDE_W-1:0]  y_inc, x_inc;

    assign k_s   = $signed({1'b0, i_rad});
    assign neg_k = -k_s;

    // next offset, j inner and i outer, then y and x
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_i = r_i;
        n_j = r_j;
        n_self = r_self;
        n_node = 1'b0;
        n_wrap = 1'b0;
        y_inc = {1'b0, r_y} + 9'd1;
        x_inc = {1'b0, r_x} + 9'd1;
        if (r_j < k_s) begin
            n_j = r_j + 4'sd1;
        end else begin
            n_j = neg_k;
            if (r_i < k_s) begin
                n_i = r_i + 4'sd1;
            end else begin
                n_i = neg_k;
                n_node = 1'b1;
                if (y_inc >= i_side) begin
                    n_y = '0;
                    if (x_inc >= i_side) begin
                        n_x = '0;
                        n_self = '0;
                        n_wrap = 1'b1;
                    end else begin
                        n_x = x_inc[tlerg_pkg::COORD_W-1:0];
                        n_self = tlerg_pkg::NODE_W'(x_inc);
                    end
                end else begin
                    n_y = y_inc[tlerg_pkg::COORD_W-1:0];
                    n_self = r_self + tlerg_pkg::NODE_W'(i_side);
                end
            end
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_i <= '0;
            r_j <= '0;
            r_self <= '0;
            r_kept <= '0;
        end else begin
            unique case (i_op)
                tlerg_pkg::WOP_RESTART: begin
                    r_x <= '0;
                    r_y <= '0;
                    r_i <= neg_k;
                    r_j <= neg_k;
                    r_self <= '0;
                    r_kept <= '0;
                end
                tlerg_pkg::WOP_STEP: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_i <= n_i;
                    r_j <= n_j;
                    r_self <= n_self;
                    if (n_node) begin
                        r_kept <= '0;
                    end
                end
                tlerg_pkg::WOP_KEEP: begin
                    if (r_kept < CW'(MAX_NEIGHBOURS)) begin
                        r_kept <= r_kept + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.x = r_x;
    assign o_stat.y = r_y;
    assign o_stat.i = r_i;
    assign o_stat.j = r_j;
    assign o_stat.self_node = r_self;
    assign o_stat.step_node = n_node;
    assign o_stat.step_wrap = n_wrap;
    assign o_stat.step_lands = tlerg_pkg::f_in_use(n_i, n_j, i_side, i_rad, i_mode);
    assign o_stat.home_in_use = tlerg_pkg::f_in_use(neg_k, neg_k, i_side, i_rad, i_mode);
    assign o_kept = r_kept;

endmodule

// ----- hdl/torus_lattice_edge_rewire_generator_core.sv -----
// channel   | handshake                   | payload
// input     | i_in_valid / o_in_stall     | i_random_word
// output    | o_out_valid / i_out_stall   | o_source_node, o_target_node, o_was_rewired,
//           |                             | o_last_of_node, o_last_of_lattice
// config    | i_cfg_we                    | i_cfg_index, i_cfg_data
// a coin word that keeps the lattice edge goes through the neighbour multiply, the edge write and the offset walk
// a coin word that calls for rewiring is taken in idle and gives no item
// a candidate is scaled, checked against the current node and compared with each kept neighbour read from the
// kept-list memory, then the edge write and the offset walk as above
// reset or a config write to one of the four known registers restarts the walk
// a stalled output holds the finished item; the next item is taken meanwhile
module torus_lattice_edge_rewire_generator_core #(
    parameter int MAX_SIDE       = tlerg_pkg::MAX_SIDE_DEF,
    parameter int MAX_RADIUS     = tlerg_pkg::MAX_RADIUS_DEF,
    parameter int MAX_NEIGHBOURS = tlerg_pkg::MAX_NEIGHBOURS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [tlerg_pkg::WORD_W-1:0]     i_random_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [tlerg_pkg::NODE_W-1:0]     o_source_node,
    output logic [tlerg_pkg::NODE_W-1:0]     o_target_node,
    output logic                             o_was_rewired,
    output logic                             o_last_of_node,
    output logic                             o_last_of_lattice,
    input  logic                             i_cfg_we,
    input  logic [tlerg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlerg_pkg::WORD_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_NEIGHBOURS);
    localparam int CW = $clog2(MAX_NEIGHBOURS + 1);

    logic [tlerg_pkg::SIDE_W-1:0] r_side_length;
    logic [tlerg_pkg::RAD_W-1:0]  r_radius;
    logic [tlerg_pkg::WORD_W-1:0] r_threshold;
    logic                         r_mode;

    tlerg_pkg::t_state r_state, n_state;
    tlerg_pkg::t_walk_op walk_op;
    tlerg_pkg::t_walk_stat stat;
    logic [CW-1:0] kept;

    logic [tlerg_pkg::SIDE_W-1:0] s_eff;
    logic [tlerg_pkg::RAD_W-1:0]  k_eff;
    logic [2*tlerg_pkg::SIDE_W-2:0] r_nn;

    logic r_await, n_await;
    logic r_pend, n_pend;
    logic r_rew, n_rew;
    logic r_fnode, n_fnode, r_fwrap, n_fwrap;
    logic [tlerg_pkg::COORD_W-1:0] r_h, n_h, r_v, n_v;
    logic [tlerg_pkg::WORD_W-1:0]  r_w, n_w;
    logic [tlerg_pkg::NODE_W-1:0]  r_tgt, n_tgt, r_src, n_src;
    logic [AW-1:0] r_idx, n_idx;
    logic [tlerg_pkg::NODE_W-1:0] rdata;
    logic mem_we;

    logic r_ov, n_ov;
    logic [tlerg_pkg::NODE_W-1:0] r_o_src, r_o_tgt;
    logic r_o_rew, r_o_node, r_o_wrap;
    logic load_out;

    logic cfg_hit;
    logic in_acc;
    logic signed [tlerg_pkg::SIDE_W:0] hs, vs, s_sgn;
    logic [tlerg_pkg::WORD_W+2*tlerg_pkg::SIDE_W-2:0] prod;
    logic [tlerg_pkg::COORD_W+tlerg_pkg::SIDE_W-1:0] vmul;

    // clamped lattice side and radius
    always_comb begin
        s_eff = r_side_length;
        if (s_eff < 9'd2) begin
            s_eff = 9'd2;
        end
        if (s_eff > tlerg_pkg::SIDE_W'(MAX_SIDE)) begin
            s_eff = tlerg_pkg::SIDE_W'(MAX_SIDE);
        end
        k_eff = r_radius;
        if (k_eff < 3'd1) begin
            k_eff = 3'd1;
        end
        if (k_eff > tlerg_pkg::RAD_W'(MAX_RADIUS)) begin
            k_eff = tlerg_pkg::RAD_W'(MAX_RADIUS);
        end
        if (tlerg_pkg::SIDE_W'(k_eff) > s_eff - 9'd1) begin
            k_eff = tlerg_pkg::RAD_W'(s_eff - 9'd1);
        end
    end

    // configuration registers
    assign cfg_hit = i_cfg_we && (i_cfg_index == tlerg_pkg::CFG_SIDE_LENGTH ||
                                  i_cfg_index == tlerg_pkg::CFG_RADIUS ||
                                  i_cfg_index == tlerg_pkg::CFG_THRESHOLD ||
                                  i_cfg_index == tlerg_pkg::CFG_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_length <= tlerg_pkg::SIDE_RST;
            r_radius <= tlerg_pkg::RADIUS_RST;
            r_threshold <= tlerg_pkg::THRESH_RST;
            r_mode <= tlerg_pkg::MODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tlerg_pkg::CFG_SIDE_LENGTH: r_side_length <= i_cfg_data[tlerg_pkg::SIDE_W-1:0];
                tlerg_pkg::CFG_RADIUS:      r_radius <= i_cfg_data[tlerg_pkg::RAD_W-1:0];
                tlerg_pkg::CFG_THRESHOLD:   r_threshold <= i_cfg_data;
                tlerg_pkg::CFG_MODE:        r_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // node count for candidate scaling
    always_ff @(posedge i_clk) begin
        r_nn <= (2*tlerg_pkg::SIDE_W-1)'(s_eff) * (2*tlerg_pkg::SIDE_W-1)'(s_eff);
    end

    tlerg_walk #(
        .MAX_NEIGHBOURS(MAX_NEIGHBOURS),
        .CW(CW)
    ) u_walk (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_op(walk_op),
        .i_side(s_eff),
        .i_rad(k_eff),
        .i_mode(r_mode),
        .o_stat(stat),
        .o_kept(kept)
    );

    tlerg_mem #(
        .DEPTH(MAX_NEIGHBOURS),
        .AW(AW)
    ) u_mem (
        .i_clk(i_clk),
        .i_we(mem_we),
        .i_waddr(kept[AW-1:0]),
        .i_wdata(r_tgt),
        .i_raddr(n_idx),
        .o_rdata(rdata)
    );

    assign o_in_stall = (r_state != tlerg_pkg::ST_IDLE);
    assign in_acc = i_in_valid && !o_in_stall;
    assign mem_we = (r_state == tlerg_pkg::ST_WRITE) && (kept < CW'(MAX_NEIGHBOURS));

    // wrapped lattice neighbour coordinates
    assign s_sgn = $signed({1'b0, s_eff});
    always_comb begin
        hs = $signed({2'b00, stat.x}) + (tlerg_pkg::SIDE_W+1)'(stat.i);
        vs = $signed({2'b00, stat.y}) + (tlerg_pkg::SIDE_W+1)'(stat.j);
        if (hs < 0) begin
            hs = hs + s_sgn;
        end else if (hs >= s_sgn) begin
            hs = hs - s_sgn;
        end
        if (vs < 0) begin
            vs = vs + s_sgn;
        end else if (vs >= s_sgn) begin
            vs = vs - s_sgn;
        end
    end

    assign vmul = r_v * s_eff;
    assign prod = r_w * r_nn;
    assign load_out = (r_state == tlerg_pkg::ST_PUSH) && (!r_ov || !i_out_stall);

    // sequencer
    always_comb begin
        n_state = r_state;
        walk_op = tlerg_pkg::WOP_HOLD;
        n_await = r_await;
        n_pend = r_pend;
        n_rew = r_rew;
        n_fnode = r_fnode;
        n_fwrap = r_fwrap;
        n_h = r_h;
        n_v = r_v;
        n_w = r_w;
        n_tgt = r_tgt;
        n_src = r_src;
        n_idx = r_idx;
        unique case (r_state)
            tlerg_pkg::ST_RESTART: begin
                walk_op = tlerg_pkg::WOP_RESTART;
                n_await = 1'b0;
                n_pend = 1'b0;
                n_state = tlerg_pkg::ST_ADV;
                if (stat.home_in_use) begin
                    n_state = tlerg_pkg::ST_IDLE;
                end
            end
            tlerg_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_w = i_random_word;
                    if (r_await) begin
                        n_state = tlerg_pkg::ST_C_MUL;
                    end else if (i_random_word > r_threshold) begin
                        n_h = hs[tlerg_pkg::COORD_W-1:0];
                        n_v = vs[tlerg_pkg::COORD_W-1:0];
                        n_state = tlerg_pkg::ST_NB_MUL;
                    end else begin
                        n_await = 1'b1;
                    end
                end
            end
            tlerg_pkg::ST_NB_MUL: begin
                n_tgt = tlerg_pkg::NODE_W'(r_h) + vmul[tlerg_pkg::NODE_W-1:0];
                n_rew = 1'b0;
                n_state = tlerg_pkg::ST_WRITE;
            end
            tlerg_pkg::ST_C_MUL: begin
                n_tgt = prod[tlerg_pkg::WORD_W+tlerg_pkg::NODE_W-1:tlerg_pkg::WORD_W];
                n_state = tlerg_pkg::ST_C_CHK;
            end
            tlerg_pkg::ST_C_CHK: begin
                n_idx = '0;
                if (r_tgt == stat.self_node) begin
                    n_state = tlerg_pkg::ST_IDLE;
                end else if (kept == '0) begin
                    n_await = 1'b0;
                    n_rew = 1'b1;
                    n_state = tlerg_pkg::ST_WRITE;
                end else begin
                    n_state = tlerg_pkg::ST_SCAN;
                end
            end
            tlerg_pkg::ST_SCAN: begin
                // one kept neighbour compared per cycle
                if (rdata == r_tgt) begin
                    n_state = tlerg_pkg::ST_IDLE;
                end else if (CW'(r_idx) + CW'(1) == kept) begin
                    n_await = 1'b0;
                    n_rew = 1'b1;
                    n_state = tlerg_pkg::ST_WRITE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            tlerg_pkg::ST_WRITE: begin
                walk_op = tlerg_pkg::WOP_KEEP;
                n_src = stat.self_node;
                n_fnode = 1'b0;
                n_fwrap = 1'b0;
                n_pend = 1'b1;
                n_state = tlerg_pkg::ST_ADV;
            end
            tlerg_pkg::ST_ADV: begin
                walk_op = tlerg_pkg::WOP_STEP;
                n_fnode = r_fnode | stat.step_node;
                n_fwrap = r_fwrap | stat.step_wrap;
                if (stat.step_lands) begin
                    n_state = r_pend ? tlerg_pkg::ST_PUSH : tlerg_pkg::ST_IDLE;
                end
            end
            tlerg_pkg::ST_PUSH: begin
                if (load_out) begin
                    n_pend = 1'b0;
                    n_state = tlerg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tlerg_pkg::ST_RESTART;
            end
        endcase
        if (cfg_hit) begin
            walk_op = tlerg_pkg::WOP_HOLD;
            n_state = tlerg_pkg::ST_RESTART;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlerg_pkg::ST_RESTART;
            r_await <= 1'b0;
            r_pend <= 1'b0;
            r_fnode <= 1'b0;
            r_fwrap <= 1'b0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_await <= n_await;
            r_pend <= n_pend;
            r_fnode <= n_fnode;
            r_fwrap <= n_fwrap;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rew <= n_rew;
        r_h <= n_h;
        r_v <= n_v;
        r_w <= n_w;
        r_tgt <= n_tgt;
        r_src <= n_src;
    end

    // output register
    always_comb begin
        n_ov = r_ov;
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
        if (load_out) begin
            n_ov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_src <= r_src;
            r_o_tgt <= r_tgt;
            r_o_rew <= r_rew;
            r_o_node <= r_fnode;
            r_o_wrap <= r_fwrap;
        end
    end

    assign o_out_valid = r_ov;
    assign o_source_node = r_o_src;
    assign o_target_node = r_o_tgt;
    assign o_was_rewired = r_o_rew;
    assign o_last_of_node = r_o_node;
    assign o_last_of_lattice = r_o_wrap;

endmodule

// ----- hdl/tlerg_checker.sv -----
`include "torus_lattice_edge_rewire_generator_core_defines.svh"

module tlerg_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [tlerg_pkg::WORD_W-1:0]     i_random_word,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [tlerg_pkg::NODE_W-1:0]     o_source_node,
    input logic [tlerg_pkg::NODE_W-1:0]     o_target_node,
    input logic                             o_was_rewired,
    input logic                             o_last_of_node,
    input logic                             o_last_of_lattice
);

    logic                            in_wait;
    logic                            out_wait;
    logic [2*tlerg_pkg::NODE_W+2:0]  out_pay;

    assign in_wait  = i_in_valid && o_in_stall;
    assign out_wait = o_out_valid && i_out_stall;
    assign out_pay  = {o_source_node, o_target_node, o_was_rewired,
                       o_last_of_node, o_last_of_lattice};

    // a stalled item holds
    `TLERG_AST_NXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(out_pay))

    // a waiting input item holds
    `TLERG_AST_NXT(a_in_hold, i_clk, i_rst_n, in_wait, i_in_valid && $stable(i_random_word))

    // an edge never loops back to its source
    `TLERG_AST_IMP(a_no_self_edge, i_clk, i_rst_n, o_out_valid, o_source_node != o_target_node)

    // the last edge of the lattice closes a node too
    `TLERG_AST_IMP(a_wrap_ends_node, i_clk, i_rst_n, o_out_valid && o_last_of_lattice, o_last_of_node)

    // nothing comes out right after reset
    `TLERG_AST_NXT_RAW(a_quiet_after_reset, i_clk, $rose(i_rst_n), !o_out_valid)

endmodule

bind torus_lattice_edge_rewire_generator_core tlerg_checker u_tlerg_checker (.*);
